@@ sv/pxu_pkg.sv @@
// Shared types, constants and widening tables for the pixel stream unpacker.
`timescale 1ns / 1ps
`default_nettype none
package pxu_pkg;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned PIXADDR_W = 24;

  typedef enum logic [1:0] {
    FMT_RGBA8888   = 2'd0,
    FMT_RGB888     = 2'd1,
    FMT_RGB565     = 2'd2,
    FMT_RGB888_XOR = 2'd3
  } pxu_fmt_e;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT  = 3'd0,
    REG_ROW_WIDTH     = 3'd1,
    REG_ROW_PITCH     = 3'd2,
    REG_START_ADDRESS = 3'd3,
    REG_FRAME_BYTES   = 3'd4
  } pxu_reg_e;

  typedef struct packed {
    pxu_fmt_e    pixel_format;
    logic [12:0] row_width;
    logic [15:0] row_pitch;
    logic [23:0] start_address;
    logic [25:0] frame_bytes;
  } pxu_cfg_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [PIXADDR_W-1:0] pixel_address;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic                 xor_into_existing;
    logic                 frame_done;
  } pxu_res_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam logic [7:0] WIDEN5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  localparam logic [7:0] WIDEN6 [64] = '{
    8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
    8'd32,  8'd36,  8'd40,  8'd45,  8'd49,  8'd53,  8'd57,  8'd61,
    8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
    8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
    8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158,
    8'd162, 8'd166, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
    8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd215, 8'd219, 8'd223,
    8'd227, 8'd231, 8'd235, 8'd239, 8'd243, 8'd247, 8'd251, 8'd255
  };

  // Bytes that make one pixel in the given format
  function automatic logic [2:0] fmt_bytes(input pxu_fmt_e fmt);
    logic [2:0] n;
    unique case (fmt)
      FMT_RGBA8888: n = 3'd4;
      FMT_RGB565:   n = 3'd2;
      default:      n = 3'd3;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/pxu_if.sv @@
// Valid/ready channel interfaces for the byte input and the pixel output.
`timescale 1ns / 1ps
`default_nettype none
interface pxu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_frame;

  modport source (output valid, output data_byte, output start_frame, input ready);
  modport sink   (input valid, input data_byte, input start_frame, output ready);
endinterface

interface pxu_pixel_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [23:0] pixel_address;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        xor_into_existing;
  logic        frame_done;

  modport source (output valid, output pixel_valid, output pixel_address, output red,
                  output green, output blue, output alpha, output xor_into_existing,
                  output frame_done, input ready);
  modport sink   (input valid, input pixel_valid, input pixel_address, input red,
                  input green, input blue, input alpha, input xor_into_existing,
                  input frame_done, output ready);
endinterface
`default_nettype wire

@@ sv/pixel_stream_unpacker.sv @@
// Top level of the pixel stream unpacker: byte stream in, framebuffer pixel writes out.
//
//   channel    | dir | handshake             | payload
//   -----------+-----+-----------------------+-----------------------------------------
//   byte_i     | in  | valid/ready           | data_byte, start_frame
//   pixel_o    | out | valid/ready           | pixel_valid, pixel_address, red, green,
//              |     |                       | blue, alpha, xor_into_existing, frame_done
//   APB        | in  | psel/penable, pready=1| five config registers at 4*i
//
// One byte per cycle while the output is not stalled; a beat is registered in the input
// register and its result in the output register.
// Row, address and byte-count state is updated in the same cycle the beat is assembled.
// Reset is asynchronous and active low and clears all control and frame state.
// A stalled output holds the input register; bytes that give no result still drain.
`timescale 1ns / 1ps
`default_nettype none
module pixel_stream_unpacker import pxu_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 4096,
  parameter int unsigned ADDRESS_BITS  = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pxu_byte_if.sink           byte_i,
  pxu_pixel_if.source        pixel_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  pxu_cfg_t cfg;
  pxu_res_t res, res_out;
  logic     res_valid, out_free, in_ready;

  pxu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pxu_unpack #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (byte_i.data_byte),
    .in_start_i  (byte_i.start_frame),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pxu_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (pixel_o.valid),
    .ready_i     (pixel_o.ready),
    .res_o       (res_out)
  );

  assign byte_i.ready              = in_ready;
  assign pixel_o.pixel_valid       = res_out.pixel_valid;
  assign pixel_o.pixel_address     = res_out.pixel_address;
  assign pixel_o.red               = res_out.red;
  assign pixel_o.green             = res_out.green;
  assign pixel_o.blue              = res_out.blue;
  assign pixel_o.alpha             = res_out.alpha;
  assign pixel_o.xor_into_existing = res_out.xor_into_existing;
  assign pixel_o.frame_done        = res_out.frame_done;

endmodule
`default_nettype wire

@@ sv/pxu_regs.sv @@
// APB configuration registers of the pixel stream unpacker.
`timescale 1ns / 1ps
`default_nettype none
module pxu_regs import pxu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output pxu_cfg_t           cfg_o
);

  pxu_cfg_t   cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PIXEL_FORMAT:  cfg_d.pixel_format  = pxu_fmt_e'(pwdata[1:0]);
        REG_ROW_WIDTH:     cfg_d.row_width     = pwdata[12:0];
        REG_ROW_PITCH:     cfg_d.row_pitch     = pwdata[15:0];
        REG_START_ADDRESS: cfg_d.start_address = pwdata[23:0];
        REG_FRAME_BYTES:   cfg_d.frame_bytes   = pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_FORMAT:  prdata = PDATA_W'(cfg_q.pixel_format);
      REG_ROW_WIDTH:     prdata = PDATA_W'(cfg_q.row_width);
      REG_ROW_PITCH:     prdata = PDATA_W'(cfg_q.row_pitch);
      REG_START_ADDRESS: prdata = PDATA_W'(cfg_q.start_address);
      REG_FRAME_BYTES:   prdata = PDATA_W'(cfg_q.frame_bytes);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format  <= FMT_RGBA8888;
      cfg_q.row_width     <= 13'd1;
      cfg_q.row_pitch     <= 16'd1;
      cfg_q.start_address <= '0;
      cfg_q.frame_bytes   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ sv/pxu_unpack.sv @@
// Input beat register, frame/row/byte state and single-pass pixel assembly.
`timescale 1ns / 1ps
`default_nettype none
module pxu_unpack import pxu_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 4096,
  parameter int unsigned ADDRESS_BITS  = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pxu_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic     in_start_i,
  input  logic     out_free_i,
  output logic     res_valid_o,
  output pxu_res_t res_o
);

  localparam int unsigned LW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned AW = ADDRESS_BITS;

  // Input beat register
  logic       stg_valid_q;
  logic [7:0] stg_byte_q;
  logic       stg_start_q;

  // Frame state
  logic [7:0]    held_q [3];
  logic [7:0]    held_d [3];
  logic [1:0]    cnt_q, cnt_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] left_q, left_d;
  logic [25:0]   rem_q, rem_d;

  logic [12:0]   w_raw;
  logic [LW-1:0] eff_w;
  logic [1:0]    cnt_e;
  logic [AW-1:0] wp_e, wp_inc, wp_jump;
  logic [LW-1:0] left_e;
  logic [25:0]   rem_e, rem_dec;
  logic [7:0]    px [4];
  logic [2:0]    count;
  logic          pix_ok, done, has_res, advance;
  logic [31:0]   wp_wide;
  logic [4:0]    r5, b5;
  logic [5:0]    g6;

  always_comb begin
    w_raw = (cfg_i.row_width == '0) ? 13'd1 : cfg_i.row_width;
    if (32'(w_raw) > 32'(MAX_ROW_WIDTH)) begin
      eff_w = LW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = LW'(w_raw);
    end
  end

  // Frame start reloads the counters before the byte is used
  always_comb begin
    if (stg_start_q) begin
      wp_e   = AW'(cfg_i.start_address);
      left_e = eff_w;
      cnt_e  = 2'd0;
      rem_e  = cfg_i.frame_bytes;
    end else begin
      wp_e   = wp_q;
      left_e = left_q;
      cnt_e  = cnt_q;
      rem_e  = rem_q;
    end
  end

  always_comb begin
    px[0]     = held_q[0];
    px[1]     = held_q[1];
    px[2]     = held_q[2];
    px[3]     = 8'd0;
    px[cnt_e] = stg_byte_q;
  end

  assign rem_dec = rem_e - 26'd1;
  assign done    = (rem_e != '0) && (rem_dec == '0);
  assign count   = {1'b0, cnt_e} + 3'd1;
  assign pix_ok  = (rem_e != '0) && (count >= fmt_bytes(cfg_i.pixel_format));
  assign has_res = pix_ok || done;

  assign wp_inc  = wp_e + AW'(1);
  assign wp_jump = wp_inc + AW'(cfg_i.row_pitch) - AW'(eff_w);
  assign wp_wide = 32'(wp_e);

  // RGB565 arrives low byte first
  assign r5 = px[1][7:3];
  assign g6 = {px[1][2:0], px[0][7:5]};
  assign b5 = px[0][4:0];

  always_comb begin
    res_o = '0;
    res_o.frame_done = done;
    if (pix_ok) begin
      res_o.pixel_valid   = 1'b1;
      res_o.pixel_address = wp_wide[PIXADDR_W-1:0];
      res_o.alpha         = ALPHA_OPAQUE;
      case (cfg_i.pixel_format)
        FMT_RGBA8888: begin
          res_o.red   = px[0];
          res_o.green = px[1];
          res_o.blue  = px[2];
          res_o.alpha = px[3];
        end
        FMT_RGB565: begin
          res_o.red   = WIDEN5[r5];
          res_o.green = WIDEN6[g6];
          res_o.blue  = WIDEN5[b5];
        end
        default: begin
          res_o.red               = px[0];
          res_o.green             = px[1];
          res_o.blue              = px[2];
          res_o.xor_into_existing = (cfg_i.pixel_format == FMT_RGB888_XOR);
        end
      endcase
    end
  end

  always_comb begin
    wp_d   = wp_e;
    left_d = left_e;
    cnt_d  = cnt_e;
    rem_d  = rem_e;
    for (int i = 0; i < 3; i++) begin
      held_d[i] = held_q[i];
    end
    if (rem_e != '0) begin
      rem_d = rem_dec;
      if (pix_ok) begin
        cnt_d = 2'd0;
        // Jump to the next framebuffer row when this pixel ends the row
        if (left_e <= LW'(1)) begin
          wp_d   = wp_jump;
          left_d = eff_w;
        end else begin
          wp_d   = wp_inc;
          left_d = left_e - LW'(1);
        end
      end else begin
        cnt_d = count[1:0];
        for (int i = 0; i < 3; i++) begin
          if (cnt_e == 2'(i)) begin
            held_d[i] = stg_byte_q;
          end
        end
      end
    end
  end

  // Hold the beat while its result cannot move on
  assign advance     = stg_valid_q && (!has_res || out_free_i);
  assign in_ready_o  = !stg_valid_q || advance;
  assign res_valid_o = stg_valid_q && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_byte_q  <= in_byte_i;
      stg_start_q <= in_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        held_q[i] <= '0;
      end
      cnt_q  <= '0;
      wp_q   <= '0;
      left_q <= '0;
      rem_q  <= '0;
    end else if (advance) begin
      for (int i = 0; i < 3; i++) begin
        held_q[i] <= held_d[i];
      end
      cnt_q  <= cnt_d;
      wp_q   <= wp_d;
      left_q <= left_d;
      rem_q  <= rem_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/pxu_out_reg.sv @@
// Result register between pixel assembly and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module pxu_out_reg import pxu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  pxu_res_t res_i,
  output logic     free_o,
  output logic     valid_o,
  input  logic     ready_i,
  output pxu_res_t res_o
);

  logic     valid_q;
  pxu_res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

@@ sv/pxu_checker.sv @@
// Port-level assertions for the pixel stream unpacker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pxu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        pixel_valid_i,
  input logic [23:0] pixel_address_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [7:0]  alpha_i,
  input logic        xor_i,
  input logic        frame_done_i
);

  // A stalled beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_address_i)
      && $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(alpha_i)
      && $stable(pixel_valid_i) && $stable(frame_done_i) && $stable(xor_i))
    else $error("output payload changed while stalled");

  a_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pixel_valid_i || frame_done_i)
    else $error("result carries neither a pixel nor frame completion");

  a_done_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> pixel_address_i == 24'd0 && red_i == 8'd0
      && green_i == 8'd0 && blue_i == 8'd0 && alpha_i == 8'd0 && !xor_i)
    else $error("pixel fields not cleared on a frame-done-only result");

  a_xor_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && xor_i |-> pixel_valid_i && alpha_i == 8'hff)
    else $error("delta pixel without opaque alpha");

endmodule

bind pixel_stream_unpacker pxu_checker u_pxu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (pixel_o.valid),
  .out_ready_i     (pixel_o.ready),
  .pixel_valid_i   (pixel_o.pixel_valid),
  .pixel_address_i (pixel_o.pixel_address),
  .red_i           (pixel_o.red),
  .green_i         (pixel_o.green),
  .blue_i          (pixel_o.blue),
  .alpha_i         (pixel_o.alpha),
  .xor_i           (pixel_o.xor_into_existing),
  .frame_done_i    (pixel_o.frame_done)
);
`default_nettype wire
